// File: design/rhp_pkg.sv
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared constants, register codes and the job record passed from the
// front end to the back end of the ranked history predictor.
// ----------------------------------------------------------------------------
package rhp_pkg;

   localparam int MAX_HISTORY = 8;
   localparam int MAX_COORDS  = 4096;
   localparam int COORD_BITS  = 16;

   localparam int SLOT_BITS   = (MAX_HISTORY > 1) ? $clog2(MAX_HISTORY) : 1;
   localparam int POS_BITS    = (MAX_COORDS > 1) ? $clog2(MAX_COORDS) : 1;
   localparam int DEPTH_BITS  = $clog2(MAX_HISTORY + 1);
   localparam int LEN_BITS    = $clog2(MAX_COORDS + 1);
   localparam int ROW_W       = MAX_HISTORY * COORD_BITS;

   localparam int DEPTH_W     = 4;
   localparam int LENGTH_W    = 13;
   localparam int CSR_W       = 13;
   localparam int RAW_W       = 16;
   localparam int RANK_W      = 3;
   localparam int RES_W       = 17;
   localparam int DIFF_W      = ((COORD_BITS > RES_W) ? COORD_BITS : RES_W) + 1;

   localparam int REQ_W       = 40;
   localparam int RSP_W       = 16;
   localparam int RSP_USER_W  = 2;

   localparam int USER_FROM_HISTORY = 0;
   localparam int USER_FAULT        = 1;

   localparam logic [DEPTH_W-1:0]  DEPTH_RESET  = DEPTH_W'(2);
   localparam logic [LENGTH_W-1:0] LENGTH_RESET = LENGTH_W'(1);

   typedef enum logic [0:0] {
      CSR_HISTORY_DEPTH = 1'b0,
      CSR_FRAME_LENGTH  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [POS_BITS-1:0]   pos;
      logic [SLOT_BITS-1:0]  wslot;
      logic [SLOT_BITS-1:0]  rank;
      logic [DEPTH_BITS-1:0] depth;
      logic                  full;
      logic                  last;
      logic                  rank_fault;
      logic [RAW_W-1:0]      raw;
      logic signed [RES_W-1:0] residual;
   } rhp_job_type;

endpackage

// File: design/rhp_ram.sv
// ----------------------------------------------------------------------------
// rhp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rhp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rhp_front.sv
// ----------------------------------------------------------------------------
// rhp_front
// Configuration registers and frame bookkeeping. Classifies each accepted
// word (fill or predict, write slot, clamped rank, end of frame) into a job.
// ----------------------------------------------------------------------------
module rhp_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [0:0]                  csr_index,
   input  logic [rhp_pkg::CSR_W-1:0]   csr_wdata,
   input  logic                        accept,
   input  logic [rhp_pkg::RAW_W-1:0]   raw_value,
   input  logic [rhp_pkg::RANK_W-1:0]  rank,
   input  logic signed [rhp_pkg::RES_W-1:0] residual,
   output rhp_pkg::rhp_job_type        job
);

   logic [rhp_pkg::DEPTH_W-1:0]    depth_ff, depth_in;
   logic [rhp_pkg::LENGTH_W-1:0]   length_ff, length_in;
   logic [rhp_pkg::POS_BITS-1:0]   pos_ff, pos_in;
   logic [rhp_pkg::DEPTH_BITS-1:0] held_ff, held_in;
   logic [rhp_pkg::SLOT_BITS-1:0]  oldest_ff, oldest_in;

   logic [rhp_pkg::DEPTH_BITS-1:0] d_eff;
   logic [rhp_pkg::LEN_BITS-1:0]   len_eff;
   logic [rhp_pkg::POS_BITS-1:0]   pos_use;
   logic                           full;
   logic                           last;

   always_comb begin
      if (depth_ff == '0) begin
         d_eff = rhp_pkg::DEPTH_BITS'(1);
      end else if (int'(depth_ff) > rhp_pkg::MAX_HISTORY) begin
         d_eff = rhp_pkg::DEPTH_BITS'(rhp_pkg::MAX_HISTORY);
      end else begin
         d_eff = rhp_pkg::DEPTH_BITS'(depth_ff);
      end
      if (length_ff == '0) begin
         len_eff = rhp_pkg::LEN_BITS'(1);
      end else if (int'(length_ff) > rhp_pkg::MAX_COORDS) begin
         len_eff = rhp_pkg::LEN_BITS'(rhp_pkg::MAX_COORDS);
      end else begin
         len_eff = rhp_pkg::LEN_BITS'(length_ff);
      end
   end

   always_comb begin
      pos_use = (rhp_pkg::LEN_BITS'(pos_ff) >= len_eff) ? '0 : pos_ff;
      full    = (held_ff >= d_eff);
      last    = ((rhp_pkg::LEN_BITS'(pos_use) + rhp_pkg::LEN_BITS'(1)) >= len_eff);

      job.pos        = pos_use;
      job.depth      = d_eff;
      job.full       = full;
      job.last       = last;
      job.raw        = raw_value;
      job.residual   = residual;
      job.wslot      = full ? oldest_ff : rhp_pkg::SLOT_BITS'(held_ff);
      if (int'(rank) >= int'(d_eff)) begin
         job.rank       = rhp_pkg::SLOT_BITS'(d_eff - rhp_pkg::DEPTH_BITS'(1));
         job.rank_fault = full;
      end else begin
         job.rank       = rhp_pkg::SLOT_BITS'(rank);
         job.rank_fault = 1'b0;
      end
   end

   always_comb begin
      depth_in  = depth_ff;
      length_in = length_ff;
      pos_in    = pos_ff;
      held_in   = held_ff;
      oldest_in = oldest_ff;
      if (csr_we) begin
         if (csr_index == rhp_pkg::CSR_HISTORY_DEPTH) begin
            depth_in = csr_wdata[rhp_pkg::DEPTH_W-1:0];
         end else begin
            length_in = csr_wdata[rhp_pkg::LENGTH_W-1:0];
         end
         pos_in    = '0;
         held_in   = '0;
         oldest_in = '0;
      end else if (accept) begin
         if (last) begin
            pos_in = '0;
            if (full) begin
               if ((int'(oldest_ff) + 1) >= int'(d_eff)) begin
                  oldest_in = '0;
               end else begin
                  oldest_in = oldest_ff + rhp_pkg::SLOT_BITS'(1);
               end
            end else begin
               held_in = held_ff + rhp_pkg::DEPTH_BITS'(1);
            end
         end else begin
            pos_in = pos_use + rhp_pkg::POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= rhp_pkg::DEPTH_RESET;
         length_ff <= rhp_pkg::LENGTH_RESET;
         pos_ff    <= '0;
         held_ff   <= '0;
         oldest_ff <= '0;
      end else begin
         depth_ff  <= depth_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
         held_ff   <= held_in;
         oldest_ff <= oldest_in;
      end
   end

endmodule

// File: design/rhp_queue.sv
// ----------------------------------------------------------------------------
// rhp_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rhp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  rhp_pkg::rhp_job_type push_job,
   output logic                 not_full,
   input  logic                 pop,
   output logic                 not_empty,
   output rhp_pkg::rhp_job_type head_job
);

   rhp_pkg::rhp_job_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_job  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/rhp_back.sv
// ----------------------------------------------------------------------------
// rhp_back
// Reads the history row of a job, ranks the held values by parallel
// compares, reconstructs and clamps the coordinate (in the fill pass takes
// the raw value), writes the row back and loads the result register.
// ----------------------------------------------------------------------------
module rhp_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  rhp_pkg::rhp_job_type           job,
   output logic                           job_pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rhp_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast,
   output logic [rhp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   typedef enum logic [0:0] {ST_READ, ST_WRITE} state_type;

   state_type                        state_ff, state_in;
   rhp_pkg::rhp_job_type             job_ff, job_in;
   logic                             valid_ff, valid_in;
   logic [rhp_pkg::RSP_W-1:0]        data_ff, data_in;
   logic                             last_ff, last_in;
   logic [rhp_pkg::RSP_USER_W-1:0]   user_ff, user_in;

   logic                             rd_en;
   logic                             wr_en;
   logic [rhp_pkg::ROW_W-1:0]        rd_row;
   logic [rhp_pkg::ROW_W-1:0]        wr_row;
   logic [rhp_pkg::COORD_BITS-1:0]   item [rhp_pkg::MAX_HISTORY];
   logic [rhp_pkg::SLOT_BITS-1:0]    order [rhp_pkg::MAX_HISTORY];
   logic [rhp_pkg::COORD_BITS-1:0]   picked;
   logic signed [rhp_pkg::DIFF_W-1:0] diff;
   logic [rhp_pkg::COORD_BITS-1:0]   value;
   logic                             fault;
   logic                             out_free;

   rhp_ram #(
      .WIDTH(rhp_pkg::ROW_W),
      .DEPTH(rhp_pkg::MAX_COORDS)
   ) u_history (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(job_ff.pos),
      .wr_data(wr_row),
      .rd_en  (rd_en),
      .rd_addr(job.pos),
      .rd_data(rd_row)
   );

   // sorted position of each held value, ties broken by slot
   always_comb begin
      for (int i = 0; i < rhp_pkg::MAX_HISTORY; i++) begin
         item[i] = rd_row[i*rhp_pkg::COORD_BITS +: rhp_pkg::COORD_BITS];
      end
      for (int i = 0; i < rhp_pkg::MAX_HISTORY; i++) begin
         order[i] = '0;
         for (int j = 0; j < rhp_pkg::MAX_HISTORY; j++) begin
            if ((j != i) && (j < int'(job_ff.depth)) &&
                ((item[j] < item[i]) || ((item[j] == item[i]) && (j < i)))) begin
               order[i] = order[i] + rhp_pkg::SLOT_BITS'(1);
            end
         end
      end
      picked = '0;
      for (int i = 0; i < rhp_pkg::MAX_HISTORY; i++) begin
         if ((i < int'(job_ff.depth)) && (order[i] == job_ff.rank)) begin
            picked = picked | item[i];
         end
      end
   end

   always_comb begin
      diff  = $signed({{(rhp_pkg::DIFF_W-rhp_pkg::COORD_BITS){1'b0}}, picked})
            - rhp_pkg::DIFF_W'(job_ff.residual);
      fault = 1'b0;
      if (job_ff.full) begin
         fault = job_ff.rank_fault;
         if (diff < 0) begin
            value = '0;
            fault = 1'b1;
         end else if (diff > $signed(rhp_pkg::DIFF_W'({rhp_pkg::COORD_BITS{1'b1}}))) begin
            value = '1;
            fault = 1'b1;
         end else begin
            value = diff[rhp_pkg::COORD_BITS-1:0];
         end
      end else begin
         value = rhp_pkg::COORD_BITS'(job_ff.raw);
      end
      for (int s = 0; s < rhp_pkg::MAX_HISTORY; s++) begin
         if (s == int'(job_ff.wslot)) begin
            wr_row[s*rhp_pkg::COORD_BITS +: rhp_pkg::COORD_BITS] = value;
         end else begin
            wr_row[s*rhp_pkg::COORD_BITS +: rhp_pkg::COORD_BITS] = item[s];
         end
      end
   end

   always_comb begin
      out_free = !valid_ff || rsp_tready;
      state_in = state_ff;
      job_in   = job_ff;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      job_pop  = 1'b0;
      case (state_ff)
         ST_READ: begin
            if (job_valid) begin
               rd_en    = 1'b1;
               job_pop  = 1'b1;
               job_in   = job;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               wr_en    = 1'b1;
               valid_in = 1'b1;
               data_in  = rhp_pkg::RSP_W'(value);
               last_in  = job_ff.last;
               user_in[rhp_pkg::USER_FROM_HISTORY] = job_ff.full;
               user_in[rhp_pkg::USER_FAULT]        = fault;
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_READ;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
      if (reset) begin
         state_ff <= ST_READ;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

// File: design/ranked_history_predictor_decode.sv
// ----------------------------------------------------------------------------
// ranked_history_predictor_decode
// Rebuilds quantised coordinates from ranked history predictions.
// Flow: an accepted word is written into the queue, its history row is read,
// then it is ranked, written back and loaded into the result register; the
// write-back waits while rsp is stalled. A new word is read only once the last
// word's read-modify-write of one row in the single history RAM is done.
// Reset: synchronous; clears the registers to their defaults, the frame
// counters and the queue. The history RAM is not cleared.
// ----------------------------------------------------------------------------
module ranked_history_predictor_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [0:0]                     csr_index,
   input  logic [rhp_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // raw_value[15:0], rank[18:16], residual[35:19], zero pad
   input  logic [rhp_pkg::REQ_W-1:0]      req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // coord_value[15:0]
   output logic [rhp_pkg::RSP_W-1:0]      rsp_tdata,
   output logic                           rsp_tlast,
   // from_history[0], fault[1]
   output logic [rhp_pkg::RSP_USER_W-1:0] rsp_tuser
);

   rhp_pkg::rhp_job_type front_job;
   rhp_pkg::rhp_job_type head_job;
   logic                 accept;
   logic                 q_not_full;
   logic                 q_not_empty;
   logic                 q_pop;

   assign req_tready = q_not_full;
   assign accept     = req_tvalid && q_not_full;

   rhp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .accept   (accept),
      .raw_value(req_tdata[15:0]),
      .rank     (req_tdata[18:16]),
      .residual ($signed(req_tdata[35:19])),
      .job      (front_job)
   );

   rhp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .not_full (q_not_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .head_job (head_job)
   );

   rhp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_not_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .rsp_tuser (rsp_tuser)
   );

endmodule

// File: bench/tb_ranked_history_predictor_decode.sv
// ----------------------------------------------------------------------------
// tb_ranked_history_predictor_decode
// Self-checking bench for the ranked history decoder. Symbol words go in on
// req with bursty, gapped timing. Results come back on rsp under a changing
// backpressure pattern. Each accepted symbol runs through a local copy of the
// history, rank and saturation logic. The rebuilt coordinate is queued and
// checked in order against rsp. Register settings are changed between
// phases: the clamped depths and lengths, up to and above 4096 coordinates.
// ----------------------------------------------------------------------------
module tb_ranked_history_predictor_decode;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [rhp_pkg::RES_W-1:0] residual;
      logic [rhp_pkg::RANK_W-1:0]       rank;
      logic [rhp_pkg::RAW_W-1:0]        raw;
   } symbol_type;

   typedef struct packed {
      logic                           fault;
      logic                           from_history;
      logic                           last;
      logic [rhp_pkg::COORD_BITS-1:0] coord;
   } coord_type;

   localparam longint COORD_TOP  = (longint'(1) << rhp_pkg::COORD_BITS) - 1;
   localparam int     FIFO_DEPTH = 4096;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           csr_we     = 1'b0;
   rhp_pkg::csr_index_type         csr_index  = rhp_pkg::CSR_HISTORY_DEPTH;
   logic [rhp_pkg::CSR_W-1:0]      csr_wdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [rhp_pkg::REQ_W-1:0]      req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [rhp_pkg::RSP_W-1:0]      rsp_tdata;
   logic                           rsp_tlast;
   logic [rhp_pkg::RSP_USER_W-1:0] rsp_tuser;

   ranked_history_predictor_decode u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // local copy of the decoder state
   logic [rhp_pkg::DEPTH_W-1:0]    depth_reg = rhp_pkg::DEPTH_RESET;
   logic [rhp_pkg::LENGTH_W-1:0]   length_reg = rhp_pkg::LENGTH_RESET;
   logic [rhp_pkg::COORD_BITS-1:0] past_coords [rhp_pkg::MAX_HISTORY][rhp_pkg::MAX_COORDS];
   int unsigned                    kept_frames = 0;
   int unsigned                    retire_slot = 0;
   int unsigned                    next_pos = 0;

   symbol_type symbol_fifo [FIFO_DEPTH];
   coord_type  coord_fifo [FIFO_DEPTH];
   int sym_wr = 0;
   int sym_rd = 0;
   int exp_wr = 0;
   int exp_rd = 0;
   int n_issued = 0;
   int n_returned = 0;

   int errors = 0;
   int n_words = 0;
   int n_predicted = 0;
   int n_flagged = 0;
   int n_settings = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_pct;
   symbol_type sent_sym;
   symbol_type seen_sym;
   coord_type  got_coord;
   coord_type  want_coord;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic coord_type rebuild_coord(symbol_type s);
      int unsigned d, len, pos, r, wslot, i, j;
      logic [rhp_pkg::COORD_BITS-1:0] ranked [rhp_pkg::MAX_HISTORY];
      logic [rhp_pkg::COORD_BITS-1:0] v;
      longint value;
      longint res;
      logic full;
      coord_type c;
      d = (depth_reg == 0) ? 1 :
          (depth_reg > rhp_pkg::MAX_HISTORY) ? rhp_pkg::MAX_HISTORY : depth_reg;
      len = (length_reg == 0) ? 1 :
            (length_reg > rhp_pkg::MAX_COORDS) ? rhp_pkg::MAX_COORDS : length_reg;
      pos = (next_pos >= len) ? 0 : next_pos;
      full = (kept_frames >= d);
      c.fault = 1'b0;
      if (full) begin
         for (i = 0; i < d; i++) ranked[i] = past_coords[i][pos];
         for (i = 1; i < d; i++) begin
            v = ranked[i];
            j = i;
            while (j > 0 && ranked[j-1] > v) begin
               ranked[j] = ranked[j-1];
               j--;
            end
            ranked[j] = v;
         end
         r = 32'(s.rank);
         if (r >= d) begin
            r = d - 1;
            c.fault = 1'b1;
         end
         res = $signed(s.residual);
         value = longint'(ranked[r]) - res;
         wslot = retire_slot % d;
      end else begin
         value = longint'(s.raw);
         wslot = kept_frames;
      end
      if (value < 0) begin
         value = 0;
         c.fault = 1'b1;
      end else if (value > COORD_TOP) begin
         value = COORD_TOP;
         c.fault = 1'b1;
      end
      past_coords[wslot][pos] = value[rhp_pkg::COORD_BITS-1:0];
      c.coord = value[rhp_pkg::COORD_BITS-1:0];
      c.from_history = full;
      c.last = (pos + 1 >= len);
      if (c.last) begin
         next_pos = 0;
         if (full) retire_slot = (retire_slot + 1) % d;
         else kept_frames++;
      end else begin
         next_pos = pos + 1;
      end
      return c;
   endfunction

   function automatic symbol_type random_symbol();
      symbol_type s;
      case ($urandom_range(0, 7))
         0: s.raw = '0;
         1: s.raw = '1;
         default: s.raw = rhp_pkg::RAW_W'($urandom);
      endcase
      s.rank = rhp_pkg::RANK_W'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
         0: s.residual = 17'sh10000;
         1: s.residual = 17'sh0FFFF;
         2, 3: s.residual = rhp_pkg::RES_W'($urandom);
         default: s.residual = rhp_pkg::RES_W'(int'($urandom_range(0, 32)) - 16);
      endcase
      return s;
   endfunction

   task automatic queue_symbol(symbol_type s);
      symbol_fifo[sym_wr % FIFO_DEPTH] = s;
      sym_wr++;
   endtask

   task automatic add_symbol(logic [rhp_pkg::RAW_W-1:0] raw,
                             logic [rhp_pkg::RANK_W-1:0] rank,
                             logic signed [rhp_pkg::RES_W-1:0] residual);
      symbol_type s;
      s.raw = raw;
      s.rank = rank;
      s.residual = residual;
      queue_symbol(s);
   endtask

   // wait for every queued word to come back, then let the pipe settle
   task automatic drain();
      while (sym_rd != sym_wr || n_returned < n_issued)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_reg(rhp_pkg::csr_index_type idx, logic [rhp_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == rhp_pkg::CSR_HISTORY_DEPTH) depth_reg = val[rhp_pkg::DEPTH_W-1:0];
      else length_reg = val[rhp_pkg::LENGTH_W-1:0];
      kept_frames = 0;
      retire_slot = 0;
      next_pos = 0;
      n_settings++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(int count, int pause_at);
      int k;
      for (k = 0; k < count; k++) begin
         if (k == pause_at) drain();
         queue_symbol(random_symbol());
      end
      drain();
   endtask

   task automatic note_mismatch(string what, coord_type want, coord_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t %s: expected coord=%h last=%b hist=%b fault=%b",
                  $realtime, what, want.coord, want.last, want.from_history, want.fault);
         $display("   got coord=%h last=%b hist=%b fault=%b",
                  got.coord, got.last, got.from_history, got.fault);
      end
   endtask

   // sender: bursts of random length, random gaps in between
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (sym_rd != sym_wr) begin
            sent_sym = symbol_fifo[sym_rd % FIFO_DEPTH];
            sym_rd++;
            n_issued++;
            req_tdata  <= rhp_pkg::REQ_W'(sent_sym);
            req_tvalid <= 1'b1;
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      cycle_count++;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_returned++;
            got_coord.coord        = rsp_tdata;
            got_coord.last         = rsp_tlast;
            got_coord.from_history = rsp_tuser[rhp_pkg::USER_FROM_HISTORY];
            got_coord.fault        = rsp_tuser[rhp_pkg::USER_FAULT];
            if (exp_rd == exp_wr) begin
               note_mismatch("unexpected word", '0, got_coord);
            end else begin
               want_coord = coord_fifo[exp_rd % FIFO_DEPTH];
               exp_rd++;
               if (got_coord !== want_coord) note_mismatch("mismatch", want_coord, got_coord);
            end
         end
         if (req_tvalid && req_tready) begin
            seen_sym = req_tdata[$bits(symbol_type)-1:0];
            want_coord = rebuild_coord(seen_sym);
            coord_fifo[exp_wr % FIFO_DEPTH] = want_coord;
            exp_wr++;
            n_words++;
            if (want_coord.from_history) n_predicted++;
            if (want_coord.fault) n_flagged++;
         end
         case ((cycle_count >> 8) % 4)
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 85;
         endcase
         rsp_tready <= ($urandom_range(1, 100) > stall_pct);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: depth 2, one coordinate per frame
      add_symbol(16'h0000, 3'd0, 17'sd0);
      add_symbol(16'hFFFF, 3'd0, 17'sd0);
      add_symbol(16'h1234, 3'd0, 17'sd0);
      add_symbol(16'h0000, 3'd1, 17'sd0);
      add_symbol(16'h0000, 3'd7, 17'sd0);
      add_symbol(16'h0000, 3'd0, 17'sd1);
      add_symbol(16'h0000, 3'd1, -17'sd1);
      add_symbol(16'h0000, 3'd1, 17'sh0FFFF);
      add_symbol(16'h0000, 3'd0, 17'sh10000);
      add_symbol(16'hFFFF, 3'd2, 17'sh05555);
      add_symbol(16'hAAAA, 3'd3, 17'sh0AAAA);
      add_symbol(16'h5555, 3'd4, -17'sd2);
      add_symbol(16'h0000, 3'd5, 17'sd3);
      add_symbol(16'h0000, 3'd6, -17'sd3);
      add_symbol(16'h0000, 3'd1, 17'sd100);
      add_symbol(16'h0000, 3'd0, -17'sd100);
      drain();

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd0);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd3);
      run_phase(120, -1);

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd4);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd7);
      run_phase(200, 100);

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd15);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd5);
      run_phase(150, -1);

      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd0);
      run_phase(100, -1);

      // upper bits of the write are dropped, depth 3
      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'h1FF3);
      run_phase(120, -1);

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd8);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd2);
      run_phase(150, -1);

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd1);
      run_phase(60, -1);

      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd8);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'd4096);
      run_phase(60, -1);

      // oversized length acts as the full 4096; the frame stays in its fill pass
      set_reg(rhp_pkg::CSR_HISTORY_DEPTH, 13'd0);
      set_reg(rhp_pkg::CSR_FRAME_LENGTH, 13'h1FFF);
      run_phase(120, -1);

      repeat (10) @(posedge clock);
      errors += exp_wr - exp_rd;
      $display("Checked %0d words over %0d register writes, depths 1..8 and frames up to %0d.",
               n_words, n_settings, rhp_pkg::MAX_COORDS);
      $display("%0d words predicted from history, %0d flagged as clamped.",
               n_predicted, n_flagged);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
